FILE: rtl/core/drd_pkg.sv
// Shared types and constants for the duplicate row detector.
`timescale 1ns / 1ps

package drd_pkg;

    localparam int DEFAULT_MAX_SIDE = 16;
    localparam int DATA_W = 32;
    localparam int CFG_W = 5;
    localparam int APB_DW = 32;
    localparam int APB_AW = 3;

    localparam logic [CFG_W-1:0] MATRIX_SIZE_RESET = 5'd16;

    // Word index of the matrix_size register (paddr bit 2).
    localparam logic REG_MATRIX_SIZE = 1'b0;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_REPORT
    } t_state;

    typedef struct packed {
        logic busy;
        logic valid;
        logic dup;
    } t_scan_status;

endpackage

FILE: rtl/core/duplicate_row_detector_top.sv
// Top level of the duplicate row detector: config port, load counter, store, scan.
`timescale 1ns / 1ps

// Channel      Dir  Signals                               Handshake
// -----------  ---  ------------------------------------  ---------------------------
// element in   in   i_element_value                       start & !busy takes a beat
// result out   out  o_duplicate_found                     o_result_valid, one cycle
// config       i/o  psel penable pwrite paddr pwdata ...  APB, pready tied high
//
// Loading takes one element per cycle while start is high and busy is low. After the last
// element of a frame the block is busy while one shared compare walks the row pairs
// element by element (read, compare), ending early on a full-row match, then raises a
// one-cycle result strobe. A one-row frame strobes in the cycle after its beat.
// Reset (i_rst_n low, synchronous) sets matrix_size to 16 and the load counter to 0;
// the store is not cleared. The receiver cannot stall: the strobe lasts one cycle.

module duplicate_row_detector_top #(
    parameter int MAX_SIDE = drd_pkg::DEFAULT_MAX_SIDE
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [drd_pkg::DATA_W-1:0]  i_element_value,
    output logic                               o_result_valid,
    output logic                               o_duplicate_found,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [drd_pkg::APB_AW-1:0]         paddr,
    input  logic [drd_pkg::APB_DW-1:0]         pwdata,
    output logic [drd_pkg::APB_DW-1:0]         prdata,
    output logic                               pready
);
    import drd_pkg::*;

    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int TW    = 2 * SW;
    localparam int CMPW  = (SW > CFG_W) ? SW : CFG_W;

    logic [CFG_W-1:0] r_matrix_size, n_matrix_size;
    logic [CW-1:0]    r_load_count, n_load_count;

    logic             w_cfg_wr;
    logic             w_accept;
    logic [SW-1:0]    w_side;
    logic [TW-1:0]    w_total;
    logic [CW-1:0]    w_count_inc;
    logic             w_frame_end;
    logic             w_launch;

    logic             w_rd_en;
    logic [AW-1:0]    w_rd_addr_a;
    logic [AW-1:0]    w_rd_addr_b;
    logic [DATA_W-1:0] w_rd_data_a;
    logic [DATA_W-1:0] w_rd_data_b;
    t_scan_status     w_status;

    // ---------------- configuration port ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        n_matrix_size = r_matrix_size;
        if (w_cfg_wr && (paddr[2] == REG_MATRIX_SIZE)) begin
            n_matrix_size = pwdata[CFG_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_MATRIX_SIZE) ? APB_DW'(r_matrix_size) : '0;

    // side in use: zero reads as one, anything above MAX_SIDE saturates
    always_comb begin
        if (r_matrix_size == '0) begin
            w_side = SW'(1);
        end else if (CMPW'(r_matrix_size) > CMPW'(MAX_SIDE)) begin
            w_side = SW'(MAX_SIDE);
        end else begin
            w_side = SW'(r_matrix_size);
        end
    end

    assign w_total = TW'(w_side) * TW'(w_side);

    // ---------------- element load ----------------
    assign busy        = w_status.busy;
    assign w_accept    = start && !busy;
    assign w_count_inc = r_load_count + CW'(1);
    // frame ends once the count reaches side*side (also if size shrank mid-frame)
    assign w_frame_end = (TW'(w_count_inc) >= w_total);
    assign w_launch    = w_accept && w_frame_end;

    always_comb begin
        n_load_count = r_load_count;
        if (w_accept) begin
            n_load_count = w_frame_end ? '0 : w_count_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix_size <= MATRIX_SIZE_RESET;
            r_load_count  <= '0;
        end else begin
            r_matrix_size <= n_matrix_size;
            r_load_count  <= n_load_count;
        end
    end

    // ---------------- store and scan ----------------
    drd_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk       (i_clk),
        .i_wr_en     (w_accept),
        .i_wr_addr   (r_load_count[AW-1:0]),
        .i_wr_data   (i_element_value),
        .i_rd_en     (w_rd_en),
        .i_rd_addr_a (w_rd_addr_a),
        .i_rd_addr_b (w_rd_addr_b),
        .o_rd_data_a (w_rd_data_a),
        .o_rd_data_b (w_rd_data_b)
    );

    drd_seq #(
        .MAX_SIDE (MAX_SIDE),
        .SW       (SW),
        .AW       (AW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_launch    (w_launch),
        .i_side      (w_side),
        .o_rd_en     (w_rd_en),
        .o_rd_addr_a (w_rd_addr_a),
        .o_rd_addr_b (w_rd_addr_b),
        .i_rd_data_a (w_rd_data_a),
        .i_rd_data_b (w_rd_data_b),
        .o_status    (w_status)
    );

    assign o_result_valid    = w_status.valid;
    assign o_duplicate_found = w_status.dup;

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_load_count < CW'(DEPTH))
        else $error("load counter ran past the store");

    a_launch_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_launch |=> (r_load_count == '0))
        else $error("load counter not cleared at frame end");

endmodule

FILE: rtl/core/drd_store.sv
// Matrix store: one write port, two registered read ports.
`timescale 1ns / 1ps

module drd_store #(
    parameter int DEPTH = drd_pkg::DEFAULT_MAX_SIDE * drd_pkg::DEFAULT_MAX_SIDE,
    parameter int AW = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [AW-1:0]               i_wr_addr,
    input  logic [drd_pkg::DATA_W-1:0]  i_wr_data,
    input  logic                        i_rd_en,
    input  logic [AW-1:0]               i_rd_addr_a,
    input  logic [AW-1:0]               i_rd_addr_b,
    output logic [drd_pkg::DATA_W-1:0]  o_rd_data_a,
    output logic [drd_pkg::DATA_W-1:0]  o_rd_data_b
);
    import drd_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data_a;
    logic [DATA_W-1:0] r_rd_data_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data_a <= r_mem[i_rd_addr_a];
            r_rd_data_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_data_a;
    assign o_rd_data_b = r_rd_data_b;

endmodule

FILE: rtl/core/drd_seq.sv
// Row-pair scan sequencer around one shared 32-bit equality compare.
`timescale 1ns / 1ps

module drd_seq #(
    parameter int MAX_SIDE = drd_pkg::DEFAULT_MAX_SIDE,
    parameter int SW = $clog2(MAX_SIDE + 1),
    parameter int AW = $clog2(MAX_SIDE * MAX_SIDE)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_launch,
    input  logic [SW-1:0]               i_side,
    output logic                        o_rd_en,
    output logic [AW-1:0]               o_rd_addr_a,
    output logic [AW-1:0]               o_rd_addr_b,
    input  logic [drd_pkg::DATA_W-1:0]  i_rd_data_a,
    input  logic [drd_pkg::DATA_W-1:0]  i_rd_data_b,
    output drd_pkg::t_scan_status       o_status
);
    import drd_pkg::*;

    t_state        r_state, n_state;
    logic [SW-1:0] r_side, n_side;
    logic [SW-1:0] r_row_a, n_row_a;
    logic [SW-1:0] r_row_b, n_row_b;
    logic [SW-1:0] r_col, n_col;
    logic [AW-1:0] r_base_a, n_base_a;
    logic [AW-1:0] r_base_b, n_base_b;
    logic          r_dup, n_dup;

    logic [AW-1:0] w_side_ext;
    logic          w_eq;
    logic          w_last_col;
    logic          w_last_b;
    logic          w_last_a;

    assign w_side_ext = AW'(r_side);
    assign w_eq       = (i_rd_data_a == i_rd_data_b);
    assign w_last_col = (r_col == r_side - SW'(1));
    assign w_last_b   = (r_row_b == r_side - SW'(1));
    assign w_last_a   = (r_row_a == r_side - SW'(2));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_launch) begin
                    n_state = (i_side == SW'(1)) ? S_REPORT : S_READ;
                end
            end
            S_READ: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if ((w_eq && w_last_col) || (!w_eq && w_last_b && w_last_a)) begin
                    n_state = S_REPORT;
                end else begin
                    n_state = S_READ;
                end
            end
            S_REPORT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // counters, flag and read port
    always_comb begin
        n_side   = r_side;
        n_row_a  = r_row_a;
        n_row_b  = r_row_b;
        n_col    = r_col;
        n_base_a = r_base_a;
        n_base_b = r_base_b;
        n_dup    = r_dup;
        unique case (r_state)
            S_IDLE: begin
                if (i_launch) begin
                    n_side   = i_side;
                    n_row_a  = '0;
                    n_row_b  = SW'(1);
                    n_col    = '0;
                    n_base_a = '0;
                    n_base_b = AW'(i_side);
                    n_dup    = 1'b0;
                end
            end
            S_CMP: begin
                if (w_eq && w_last_col) begin
                    n_dup = 1'b1;
                end else if (w_eq) begin
                    n_col = r_col + SW'(1);
                end else if (!(w_last_b && w_last_a)) begin
                    // mismatch: move on to the next row pair
                    n_col = '0;
                    if (w_last_b) begin
                        n_row_a  = r_row_a + SW'(1);
                        n_row_b  = r_row_a + SW'(2);
                        n_base_a = r_base_a + w_side_ext;
                        n_base_b = r_base_a + (w_side_ext << 1);
                    end else begin
                        n_row_b  = r_row_b + SW'(1);
                        n_base_b = r_base_b + w_side_ext;
                    end
                end
            end
            S_READ, S_REPORT: begin
            end
            default: begin
            end
        endcase
    end

    assign o_rd_en     = (r_state == S_READ);
    assign o_rd_addr_a = r_base_a + AW'(r_col);
    assign o_rd_addr_b = r_base_b + AW'(r_col);

    assign o_status.busy  = (r_state != S_IDLE);
    assign o_status.valid = (r_state == S_REPORT);
    assign o_status.dup   = r_dup;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side   <= n_side;
        r_row_a  <= n_row_a;
        r_row_b  <= n_row_b;
        r_col    <= n_col;
        r_base_a <= n_base_a;
        r_base_b <= n_base_b;
        r_dup    <= n_dup;
    end

    a_one_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.valid |=> !o_status.valid)
        else $error("result strobe longer than one cycle");

    a_cmp_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> ($past(r_state) == S_READ))
        else $error("compare without a preceding read");

    a_launch_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_launch && !o_status.busy) |=> o_status.busy)
        else $error("launch did not start a scan");

endmodule
